/* src/mamm_pkg.sv */
// Package for the sliding-window moving average with min/max tracking.
// Holds shared widths, register indexes, sentinels, the sequencer state type
// and the extreme tracker control struct. Depends on nothing.
`default_nettype none

package mamm_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int SAMPLE_W       = 16;
  localparam int AVG_W          = 24;
  localparam int FRAC_W         = 8;
  localparam int WS_W           = 7;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int WS_RESET       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE  = 2'd1;

  localparam logic signed [SAMPLE_W-1:0] INIT_RESET = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] MAX_SENT   = -16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] MIN_SENT   = 16'sd32767;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_START,
    ST_SCAN,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic restart;
    logic update;
    logic step;
  } scan_ctrl_t;

endpackage

`default_nettype wire

/* src/mamm_win.sv */
// Window sample memory with a fill count for the moving average block.
// Entries not yet written since a restart read back as the init value.
// Depends on mamm_pkg.
`default_nettype none

module mamm_win #(
  parameter int WINDOW_MAX = mamm_pkg::WINDOW_MAX_DEF,
  parameter int AW         = 6,
  parameter int SZ_W       = 7
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 clear_i,
  input  wire logic signed [mamm_pkg::SAMPLE_W-1:0] init_i,
  input  wire logic [AW-1:0]                  rd_addr_i,
  output logic signed [mamm_pkg::SAMPLE_W-1:0] rd_data_o,
  input  wire                                 wr_en_i,
  input  wire logic [AW-1:0]                  wr_addr_i,
  input  wire logic signed [mamm_pkg::SAMPLE_W-1:0] wr_data_i
);

  logic signed [mamm_pkg::SAMPLE_W-1:0] mem [WINDOW_MAX];
  logic signed [mamm_pkg::SAMPLE_W-1:0] rd_q_r;
  logic                                 rd_hit_r;
  logic [SZ_W-1:0]                      fill_r;
  logic [SZ_W-1:0]                      fill_nxt;

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q_r   <= mem[rd_addr_i];
    rd_hit_r <= (SZ_W'(rd_addr_i) < fill_r);
  end

  // Writes walk the window in order from entry zero, so the written entries
  // always form a prefix whose length is the fill count.
  always_comb begin
    fill_nxt = fill_r;
    if (clear_i) begin
      fill_nxt = '0;
    end else if (wr_en_i && (SZ_W'(wr_addr_i) == fill_r)) begin
      fill_nxt = fill_r + SZ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign rd_data_o = rd_hit_r ? rd_q_r : init_i;

endmodule

`default_nettype wire

/* src/mamm_scan.sv */
// Tracked maximum and minimum with a shared compare step for window rescans.
// Depends on mamm_pkg for the sentinels and the control struct.
`default_nettype none

module mamm_scan (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire mamm_pkg::scan_ctrl_t           ctrl_i,
  input  wire logic signed [mamm_pkg::SAMPLE_W-1:0] v_in_i,
  input  wire logic signed [mamm_pkg::SAMPLE_W-1:0] v_out_i,
  input  wire logic signed [mamm_pkg::SAMPLE_W-1:0] data_i,
  output logic signed [mamm_pkg::SAMPLE_W-1:0] max_o,
  output logic signed [mamm_pkg::SAMPLE_W-1:0] min_o,
  output logic                                need_scan_o
);

  logic signed [mamm_pkg::SAMPLE_W-1:0] max_r, max_nxt;
  logic signed [mamm_pkg::SAMPLE_W-1:0] min_r, min_nxt;
  logic                                 fmax_r, fmax_nxt;
  logic                                 fmin_r, fmin_nxt;

  always_comb begin
    max_nxt  = max_r;
    min_nxt  = min_r;
    fmax_nxt = fmax_r;
    fmin_nxt = fmin_r;
    if (ctrl_i.restart) begin
      max_nxt  = mamm_pkg::MAX_SENT;
      min_nxt  = mamm_pkg::MIN_SENT;
      fmax_nxt = 1'b0;
      fmin_nxt = 1'b0;
    end else if (ctrl_i.update) begin
      // A new extreme wins outright; losing the current extreme restarts
      // that side from its sentinel and flags it for a rescan.
      fmax_nxt = 1'b0;
      if (max_r < v_in_i) begin
        max_nxt = v_in_i;
      end else if (max_r == v_out_i) begin
        max_nxt  = mamm_pkg::MAX_SENT;
        fmax_nxt = 1'b1;
      end
      fmin_nxt = 1'b0;
      if (min_r > v_in_i) begin
        min_nxt = v_in_i;
      end else if (min_r == v_out_i) begin
        min_nxt  = mamm_pkg::MIN_SENT;
        fmin_nxt = 1'b1;
      end
    end else if (ctrl_i.step) begin
      if (fmax_r && (max_r < data_i)) begin
        max_nxt = data_i;
      end
      if (fmin_r && (min_r > data_i)) begin
        min_nxt = data_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= mamm_pkg::MAX_SENT;
      min_r  <= mamm_pkg::MIN_SENT;
      fmax_r <= 1'b0;
      fmin_r <= 1'b0;
    end else begin
      max_r  <= max_nxt;
      min_r  <= min_nxt;
      fmax_r <= fmax_nxt;
      fmin_r <= fmin_nxt;
    end
  end

  assign max_o       = max_r;
  assign min_o       = min_r;
  assign need_scan_o = fmax_r | fmin_r;

endmodule

`default_nettype wire

/* src/mamm_div.sv */
// Serial restoring divider: (sum * 256) / size, truncated toward zero.
// One quotient bit per cycle on the magnitude, sign applied at the end.
// Depends on mamm_pkg for the fraction and result widths.
`default_nettype none

module mamm_div #(
  parameter int SUM_W = 23,
  parameter int SZ_W  = 7
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start_i,
  input  wire logic signed [SUM_W-1:0]     dividend_i,
  input  wire logic [SZ_W-1:0]             divisor_i,
  output logic                             busy_o,
  output logic signed [mamm_pkg::AVG_W-1:0] quot_o
);

  localparam int DW    = SUM_W + mamm_pkg::FRAC_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [SUM_W-1:0] mag;
  logic [DW-1:0]    dvd_r;
  logic [DW-1:0]    q_r;
  logic [SZ_W-1:0]  rem_r;
  logic [SZ_W-1:0]  dsr_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SZ_W:0]    rem_sh;
  logic [SZ_W:0]    rem_dif;
  logic             ge;
  logic [DW-1:0]    q_sgn;

  assign mag     = dividend_i[SUM_W-1] ? (~dividend_i + SUM_W'(1)) : dividend_i;
  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign rem_dif = rem_sh - {1'b0, dsr_r};
  assign ge      = (rem_sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (start_i) begin
      dvd_r <= {mag, {mamm_pkg::FRAC_W{1'b0}}};
      q_r   <= '0;
      rem_r <= '0;
      dsr_r <= divisor_i;
      neg_r <= dividend_i[SUM_W-1];
    end else if (busy_o) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      q_r   <= {q_r[DW-2:0], ge};
      rem_r <= ge ? rem_dif[SZ_W-1:0] : rem_sh[SZ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_i) begin
      cnt_r <= CNT_W'(DW);
    end else if (busy_o) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign busy_o = (cnt_r != '0);
  assign q_sgn  = neg_r ? (~q_r + DW'(1)) : q_r;
  assign quot_o = q_sgn[mamm_pkg::AVG_W-1:0];

endmodule

`default_nettype wire

/* src/moving_average_min_max_window_top.sv */
// Top level of the sliding-window moving average with min/max tracking.
// Instantiates mamm_win, mamm_scan and mamm_div; depends on mamm_pkg.
//
// Usage: each input transfer (in_valid high, in_stall low) pushes one signed
// sample into a circular window of window_size entries. Exactly one result
// transfer follows per sample: the window mean with 8 fraction bits
// (truncated toward zero) and the tracked maximum and minimum.
// An input transfer passes the update state and the divider start state;
// the result then waits for the divider, and when the departing sample was
// the tracked extreme, also for a rescan that walks the memory's single
// read port entry by entry. The divider runs alongside that walk, and the
// result is loaded once both are done and the output register is free.
// The result sits in an output register; the next sample can be taken in the
// cycle after it is loaded, even while it still waits, and a stalled result
// holds its value until the transfer completes. One sample is in flight.
// Writing register 0 (window_size) or 1 (init_value) restarts the filter:
// the window reads as init_value everywhere, the running sum is rebuilt
// by a multiply, and in_stall is high while the rebuild is pending. Reset
// does the same with window_size 16 and init_value 0. No memory clearing
// pass is needed; a fill count marks the entries written since restart.
`default_nettype none

module moving_average_min_max_window_top #(
  parameter int WINDOW_MAX = mamm_pkg::WINDOW_MAX_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_we,
  input  wire logic [mamm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mamm_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire logic signed [mamm_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic signed [mamm_pkg::AVG_W-1:0]      out_average,
  output logic signed [mamm_pkg::SAMPLE_W-1:0]   out_window_max,
  output logic signed [mamm_pkg::SAMPLE_W-1:0]   out_window_min
);

  localparam int SW         = mamm_pkg::SAMPLE_W;
  localparam int AW         = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SZ_W       = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W      = SW + SZ_W;
  localparam int RESET_SIZE = (mamm_pkg::WS_RESET > WINDOW_MAX) ?
                              WINDOW_MAX : mamm_pkg::WS_RESET;

  mamm_pkg::state_t state_r, state_nxt;

  // Configuration and restart.
  logic [SZ_W-1:0]          size_r;
  logic signed [SW-1:0]     init_r;
  logic                     pend_r;
  logic                     cfg_restart;
  logic [mamm_pkg::WS_W-1:0] ws_in;
  logic [SZ_W-1:0]          size_in;
  logic signed [SUM_W:0]    prod_full;

  // Per-item state.
  logic [AW-1:0]            oldest_r;
  logic [AW-1:0]            idx_r;
  logic [AW-1:0]            idx_eff;
  logic [SZ_W-1:0]          idx_p1;
  logic signed [SW-1:0]     sample_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [SZ_W-1:0]          scan_cnt_r;
  logic                     scan_last;
  logic                     scan_dv_r;

  // Sequencer outputs.
  logic                     in_acc;
  logic                     out_free;
  logic                     done_ok;
  logic                     out_load;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic                     div_start;
  mamm_pkg::scan_ctrl_t     scan_ctrl;

  // Unit results.
  logic signed [SW-1:0]             win_data;
  logic signed [SW-1:0]             trk_max;
  logic signed [SW-1:0]             trk_min;
  logic                             need_scan;
  logic                             div_busy;
  logic signed [mamm_pkg::AVG_W-1:0] div_q;

  // Output register.
  logic                             out_valid_r;
  logic signed [mamm_pkg::AVG_W-1:0] out_avg_r;
  logic signed [SW-1:0]             out_max_r;
  logic signed [SW-1:0]             out_min_r;

  // A write to an index outside the register list is ignored entirely.
  assign cfg_restart = cfg_we && ((cfg_index == mamm_pkg::CFG_WINDOW_SIZE) ||
                                  (cfg_index == mamm_pkg::CFG_INIT_VALUE));

  // Only the low 7 bits of the write count: size zero acts as one, and above the memory depth it saturates.
  assign ws_in = cfg_wdata[mamm_pkg::WS_W-1:0];
  always_comb begin
    if (ws_in == '0) begin
      size_in = SZ_W'(1);
    end else if (32'(ws_in) > WINDOW_MAX) begin
      size_in = SZ_W'(WINDOW_MAX);
    end else begin
      size_in = SZ_W'(ws_in);
    end
  end

  assign prod_full = init_r * $signed({1'b0, size_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SZ_W'(RESET_SIZE);
      init_r <= mamm_pkg::INIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mamm_pkg::CFG_WINDOW_SIZE: size_r <= size_in;
        mamm_pkg::CFG_INIT_VALUE:  init_r <= $signed(cfg_wdata[SW-1:0]);
        default: ;
      endcase
    end
  end

  // Index bookkeeping.
  assign idx_eff   = (SZ_W'(oldest_r) >= size_r) ? '0 : oldest_r;
  assign idx_p1    = SZ_W'(idx_r) + SZ_W'(1);
  assign scan_last = (scan_cnt_r == (size_r - SZ_W'(1)));

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign done_ok  = !div_busy && !scan_dv_r && out_free;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mamm_pkg::ST_IDLE:  if (in_acc) state_nxt = mamm_pkg::ST_UPD;
      mamm_pkg::ST_UPD:   state_nxt = mamm_pkg::ST_START;
      mamm_pkg::ST_START: state_nxt = need_scan ? mamm_pkg::ST_SCAN : mamm_pkg::ST_WAIT;
      mamm_pkg::ST_SCAN:  if (scan_last) state_nxt = mamm_pkg::ST_WAIT;
      mamm_pkg::ST_WAIT:  if (done_ok) state_nxt = mamm_pkg::ST_IDLE;
      default:            state_nxt = mamm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall          = 1'b1;
    rd_addr           = idx_eff;
    wr_en             = 1'b0;
    div_start         = 1'b0;
    out_load          = 1'b0;
    scan_ctrl.restart = cfg_restart;
    scan_ctrl.update  = 1'b0;
    scan_ctrl.step    = scan_dv_r;
    unique case (state_r)
      mamm_pkg::ST_IDLE: begin
        in_stall = pend_r;
      end
      mamm_pkg::ST_UPD: begin
        wr_en            = 1'b1;
        scan_ctrl.update = 1'b1;
      end
      mamm_pkg::ST_START: begin
        div_start = 1'b1;
      end
      mamm_pkg::ST_SCAN: begin
        rd_addr = scan_cnt_r[AW-1:0];
      end
      mamm_pkg::ST_WAIT: begin
        out_load = done_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mamm_pkg::ST_IDLE;
      pend_r    <= 1'b1;
      oldest_r  <= '0;
      sum_r     <= '0;
      scan_dv_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      scan_dv_r <= (state_r == mamm_pkg::ST_SCAN);
      if (cfg_restart) begin
        pend_r   <= 1'b1;
        oldest_r <= '0;
      end else if (pend_r) begin
        // Rebuild the running sum from the settled registers.
        pend_r <= 1'b0;
        sum_r  <= prod_full[SUM_W-1:0];
      end else if (state_r == mamm_pkg::ST_UPD) begin
        sum_r    <= sum_r + SUM_W'(sample_r) - SUM_W'(win_data);
        oldest_r <= (idx_p1 >= size_r) ? '0 : idx_p1[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r    <= idx_eff;
      sample_r <= in_sample;
    end
    if (state_r == mamm_pkg::ST_START) begin
      scan_cnt_r <= '0;
    end else if (state_r == mamm_pkg::ST_SCAN) begin
      scan_cnt_r <= scan_cnt_r + SZ_W'(1);
    end
  end

  mamm_win #(
    .WINDOW_MAX (WINDOW_MAX),
    .AW         (AW),
    .SZ_W       (SZ_W)
  ) u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_i   (cfg_restart),
    .init_i    (init_r),
    .rd_addr_i (rd_addr),
    .rd_data_o (win_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_r),
    .wr_data_i (sample_r)
  );

  mamm_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl_i      (scan_ctrl),
    .v_in_i      (sample_r),
    .v_out_i     (win_data),
    .data_i      (win_data),
    .max_o       (trk_max),
    .min_o       (trk_min),
    .need_scan_o (need_scan)
  );

  mamm_div #(
    .SUM_W (SUM_W),
    .SZ_W  (SZ_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (sum_r),
    .divisor_i  (size_r),
    .busy_o     (div_busy),
    .quot_o     (div_q)
  );

  // Output register: holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg_r <= div_q;
      out_max_r <= trk_max;
      out_min_r <= trk_min;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_average    = out_avg_r;
  assign out_window_max = out_max_r;
  assign out_window_min = out_min_r;

endmodule

`default_nettype wire

/* src/mamm_checker.sv */
// Port-level checker for the moving average block, bound to its top level.
// Depends on mamm_pkg for port widths and register indexes.
`default_nettype none

module mamm_port_checker (
  input wire                                    clk,
  input wire                                    rst_n,
  input wire                                    cfg_we,
  input wire logic [mamm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input wire                                    in_valid,
  input wire                                    in_stall,
  input wire                                    out_valid,
  input wire                                    out_stall,
  input wire logic signed [mamm_pkg::AVG_W-1:0] out_average,
  input wire logic signed [mamm_pkg::SAMPLE_W-1:0] out_window_max,
  input wire logic signed [mamm_pkg::SAMPLE_W-1:0] out_window_min
);

  // Reset empties the output register and holds off input while the
  // running sum is rebuilt.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_stall))
    else $error("output or input not quiet after reset");

  // One sample at a time: the cycle after an input transfer is stalled.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a sample is in flight");

  // A register write restarts the filter and blocks input in the cycle after it.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && ((cfg_index == mamm_pkg::CFG_WINDOW_SIZE) ||
                (cfg_index == mamm_pkg::CFG_INIT_VALUE))) |=> in_stall)
    else $error("input not stalled after restart");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_average) &&
      $stable(out_window_max) && $stable(out_window_min)))
    else $error("stalled result changed");

endmodule

bind moving_average_min_max_window_top mamm_port_checker u_mamm_checker (.*);

`default_nettype wire
